>>> rtl/gtp_pkg.sv
// Shared types, byte codes and limits for the GBK text paginator.
package gtp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 20;
   localparam int START_BITS          = 20;
   localparam int TOTAL_BITS          = 21;
   localparam int RSP_DEPTH           = 3;

   localparam logic [7:0] CPL_RESET = 8'd40;
   localparam logic [7:0] LPP_RESET = 8'd22;

   // register indexes of the write port
   localparam logic CSR_LINE_UNITS = 1'b0;
   localparam logic CSR_PAGE_LINES = 1'b1;

   // byte codes
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] LEAD_LO    = 8'h81;
   localparam logic [7:0] LEAD_HI    = 8'hFE;
   localparam logic [7:0] TRAIL_LO   = 8'h40;
   localparam logic [7:0] TRAIL_HI   = 8'hFE;
   localparam logic [7:0] TRAIL_GAP  = 8'h7F;

   localparam logic [TOTAL_BITS-1:0] PAGE_CAP = 21'h100000;
   localparam logic [START_BITS-1:0] NUM_MAX  = 20'hFFFFF;

   typedef struct packed {
      logic                  page_valid;
      logic [START_BITS-1:0] page_offset;
      logic [START_BITS-1:0] page_number;
      logic [TOTAL_BITS-1:0] page_total;
      logic                  done_res;
      logic                  last_result;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]            line_width_used;
      logic [7:0]            lines_on_page;
      logic [TOTAL_BITS-1:0] pages_found;
      logic                  page_open_pending;
      logic                  carriage_return_held;
      logic                  lead_byte_held;
   } cursor_type;

   localparam cursor_type CURSOR_RESET = '{
      line_width_used:      8'd0,
      lines_on_page:        8'd0,
      pages_found:          '0,
      page_open_pending:    1'b1,
      carriage_return_held: 1'b0,
      lead_byte_held:       1'b0
   };

endpackage

>>> rtl/gtp_step.sv
// Combinational per-byte update of the layout cursor and the results it raises.
module gtp_step import gtp_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  cursor_type             cursor,
   input  logic [OFFSET_BITS-1:0] byte_pos,
   input  logic [7:0]             line_units,
   input  logic [7:0]             page_lines,
   input  logic [7:0]             text_byte,
   input  logic                   end_of_text,
   output cursor_type             cursor_next,
   output logic [OFFSET_BITS-1:0] byte_pos_next,
   output rsp_item_type           item_first,
   output rsp_item_type           item_second,
   output logic [1:0]             item_count
);

   localparam logic [OFFSET_BITS-1:0] POS_TOP = '1;

   always_comb begin
      logic [8:0]             lwu;
      logic [8:0]             lop;
      logic [8:0]             eff_cpl;
      logic [8:0]             eff_lpp;
      logic [TOTAL_BITS-1:0]  pf;
      logic                   pend;
      logic                   crh;
      logic                   lbh;
      logic                   do_plain;
      logic                   skip;
      logic                   pg_v;
      logic [OFFSET_BITS-1:0] pg_off;
      logic [OFFSET_BITS-1:0] lead_off;
      logic [START_BITS-1:0]  pg_num;
      logic [TOTAL_BITS-1:0]  pg_tot;
      logic [31:0]            off_wide;
      logic                   trail_ok;
      rsp_item_type           page_item;
      rsp_item_type           done_item;

      lwu      = {1'b0, cursor.line_width_used};
      lop      = {1'b0, cursor.lines_on_page};
      pf       = cursor.pages_found;
      pend     = cursor.page_open_pending;
      crh      = cursor.carriage_return_held;
      lbh      = cursor.lead_byte_held;
      eff_cpl  = (line_units == 8'd0) ? 9'd1 : {1'b0, line_units};
      eff_lpp  = (page_lines == 8'd0) ? 9'd1 : {1'b0, page_lines};
      do_plain = 1'b0;
      skip     = 1'b0;
      pg_v     = 1'b0;
      pg_off   = byte_pos;
      lead_off = byte_pos;
      trail_ok = (text_byte >= TRAIL_LO) && (text_byte <= TRAIL_HI) &&
                 (text_byte != TRAIL_GAP);

      if (lbh) begin
         lbh = 1'b0;
         if (trail_ok) begin
            // pair would overflow a non-empty line: break before the lead byte
            if ((lwu != 9'd0) && (lwu + 9'd2 > eff_cpl)) begin
               lwu = 9'd0;
               lop = lop + 9'd1;
               if (lop >= eff_lpp) begin
                  lop  = 9'd0;
                  pend = 1'b1;
               end
               if ((byte_pos != '0) && (byte_pos != POS_TOP)) begin
                  lead_off = byte_pos - OFFSET_BITS'(1);
               end
               if (pend) begin
                  pend   = 1'b0;
                  pg_v   = 1'b1;
                  pg_off = lead_off;
               end
            end
            lwu = lwu + 9'd2;
            if (lwu >= eff_cpl) begin
               lwu = 9'd0;
               lop = lop + 9'd1;
               if (lop >= eff_lpp) begin
                  lop  = 9'd0;
                  pend = 1'b1;
               end
            end
         end else begin
            // bad trail: lead stands alone as one unit
            lwu = lwu + 9'd1;
            if (lwu >= eff_cpl) begin
               lwu = 9'd0;
               lop = lop + 9'd1;
               if (lop >= eff_lpp) begin
                  lop  = 9'd0;
                  pend = 1'b1;
               end
            end
            do_plain = 1'b1;
         end
      end else begin
         do_plain = 1'b1;
      end

      if (do_plain) begin
         if (crh) begin
            crh  = 1'b0;
            skip = (text_byte == BYTE_LF);
         end
         if (!skip) begin
            if (pend) begin
               pend   = 1'b0;
               pg_v   = 1'b1;
               pg_off = byte_pos;
            end
            if ((text_byte == BYTE_LF) || (text_byte == BYTE_CR)) begin
               lwu = 9'd0;
               lop = lop + 9'd1;
               if (lop >= eff_lpp) begin
                  lop  = 9'd0;
                  pend = 1'b1;
               end
               crh = (text_byte == BYTE_CR) && !end_of_text;
            end else if ((text_byte < CTRL_LIMIT) && (text_byte != BYTE_TAB)) begin
               // drop other control bytes
            end else if ((text_byte >= LEAD_LO) && (text_byte <= LEAD_HI) &&
                         !end_of_text) begin
               lbh = 1'b1;
            end else begin
               lwu = lwu + 9'd1;
               if (lwu >= eff_cpl) begin
                  lwu = 9'd0;
                  lop = lop + 9'd1;
                  if (lop >= eff_lpp) begin
                     lop  = 9'd0;
                     pend = 1'b1;
                  end
               end
            end
         end
      end

      pg_num = (pf > TOTAL_BITS'(NUM_MAX)) ? NUM_MAX : pf[START_BITS-1:0];
      pg_tot = (pf >= PAGE_CAP) ? PAGE_CAP : pf + TOTAL_BITS'(1);
      if (pg_v) begin
         pf = pg_tot;
      end
      off_wide = 32'(pg_off);

      page_item.page_valid  = 1'b1;
      page_item.page_offset = off_wide[START_BITS-1:0];
      page_item.page_number = pg_num;
      page_item.page_total  = pg_tot;
      page_item.done_res    = 1'b0;
      page_item.last_result = !end_of_text;

      done_item.page_valid  = 1'b0;
      done_item.page_offset = '0;
      done_item.page_number = '0;
      done_item.page_total  = pf;
      done_item.done_res    = 1'b1;
      done_item.last_result = 1'b1;

      item_first  = pg_v ? page_item : done_item;
      item_second = done_item;
      item_count  = {1'b0, pg_v} + {1'b0, end_of_text};

      byte_pos_next = (byte_pos != POS_TOP) ? byte_pos + OFFSET_BITS'(1) : byte_pos;

      cursor_next.line_width_used      = lwu[7:0];
      cursor_next.lines_on_page        = lop[7:0];
      cursor_next.pages_found          = pf;
      cursor_next.page_open_pending    = pend;
      cursor_next.carriage_return_held = crh;
      cursor_next.lead_byte_held       = lbh;

      // end of text: return to the start-of-text state
      if (end_of_text) begin
         cursor_next   = CURSOR_RESET;
         byte_pos_next = '0;
      end
   end

endmodule

>>> rtl/gtp_rsp_queue.sv
// Small shift queue that takes up to two result items a cycle and hands out one while rsp_stall is low.
module gtp_rsp_queue import gtp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsp_item_type push_first,
   input  rsp_item_type push_second,
   input  logic [1:0]   push_count,
   output logic         room_ok,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int CNT_BITS = $clog2(RSP_DEPTH + 1);

   rsp_item_type          entry_ff [RSP_DEPTH];
   rsp_item_type          entry_in [RSP_DEPTH];
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   // hold off new items unless two free slots are certain
   assign room_ok   = (count_ff <= CNT_BITS'(RSP_DEPTH - 2));

   always_comb begin
      rsp_item_type        shifted [RSP_DEPTH];
      rsp_item_type        pushed [2];
      logic [CNT_BITS-1:0] base;
      logic [CNT_BITS-1:0] sel;

      for (int i = 0; i < RSP_DEPTH - 1; i++) begin
         shifted[i] = entry_ff[i + 1];
      end
      shifted[RSP_DEPTH-1] = entry_ff[RSP_DEPTH-1];
      pushed[0] = push_first;
      pushed[1] = push_second;
      base      = count_ff - CNT_BITS'(pop);

      for (int i = 0; i < RSP_DEPTH; i++) begin
         sel = CNT_BITS'(i) - base;
         if (CNT_BITS'(i) < base) begin
            entry_in[i] = pop ? shifted[i] : entry_ff[i];
         end else if (sel < CNT_BITS'(push_count)) begin
            entry_in[i] = pushed[sel[0]];
         end else begin
            entry_in[i] = entry_ff[i];
         end
      end
      count_in = base + CNT_BITS'(push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

>>> rtl/gbk_text_paginator_core.sv
// Top level of the GBK text paginator: cursor registers, byte step and result queue.
//
// Usage: feed the text one byte per item on the req_ channel (valid/stall);
// mark the final byte with req_end_of_text. For each byte that opens a page
// an item on the rsp_ channel carries page_valid, the page's byte offset,
// its zero-based number and the running page count. After the final byte
// one more item follows with done_res set and the final count in page_total;
// rsp_last_result marks the last item raised by one input byte.
// Timing: a byte's results enter the output queue at the edge that takes it
// and show on rsp_ from the next cycle if the queue was empty. One byte per
// cycle is sustained while rsp_stall is low and each byte raises at most one
// result; the output side, one item per cycle while not stalled, sets the pace otherwise.
// The queue holds three items; req_stall rises once two of them are filled,
// so a stalled receiver backs bytes up after two pending items.
// Reset (synchronous, active high) empties the queue, returns the cursor to
// the start of a text and sets the line width to 40 and page height to 22.
// csr_ writes are taken at any edge with csr_write_enable high; write them
// only between texts while the queue is empty.
module gbk_text_paginator_core import gtp_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [7:0]            csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_page_valid,
   output logic [START_BITS-1:0] rsp_page_offset,
   output logic [START_BITS-1:0] rsp_page_number,
   output logic [TOTAL_BITS-1:0] rsp_page_total,
   output logic                  rsp_done_res,
   output logic                  rsp_last_result
);

   logic [7:0]             line_units_ff;
   logic [7:0]             page_lines_ff;
   cursor_type             cursor_ff;
   cursor_type             cursor_in;
   logic [OFFSET_BITS-1:0] byte_pos_ff;
   logic [OFFSET_BITS-1:0] byte_pos_in;
   rsp_item_type           item_first;
   rsp_item_type           item_second;
   logic [1:0]             item_count;
   logic [1:0]             push_count;
   logic                   room_ok;
   logic                   accept;
   rsp_item_type           rsp_item;

   assign req_stall  = !room_ok;
   assign accept     = req_valid && room_ok;
   // push nothing unless a byte is taken this cycle
   assign push_count = accept ? item_count : 2'd0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_units_ff <= CPL_RESET;
         page_lines_ff <= LPP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LINE_UNITS: line_units_ff <= csr_write_data;
            CSR_PAGE_LINES: page_lines_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   gtp_step #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .cursor        (cursor_ff),
      .byte_pos      (byte_pos_ff),
      .line_units    (line_units_ff),
      .page_lines    (page_lines_ff),
      .text_byte     (req_text_byte),
      .end_of_text   (req_end_of_text),
      .cursor_next   (cursor_in),
      .byte_pos_next (byte_pos_in),
      .item_first    (item_first),
      .item_second   (item_second),
      .item_count    (item_count)
   );

   // advance the cursor only on a taken byte
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= CURSOR_RESET;
         byte_pos_ff <= '0;
      end else if (accept) begin
         cursor_ff   <= cursor_in;
         byte_pos_ff <= byte_pos_in;
      end
   end

   gtp_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_first  (item_first),
      .push_second (item_second),
      .push_count  (push_count),
      .room_ok     (room_ok),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

   assign rsp_page_valid  = rsp_item.page_valid;
   assign rsp_page_offset = rsp_item.page_offset;
   assign rsp_page_number = rsp_item.page_number;
   assign rsp_page_total  = rsp_item.page_total;
   assign rsp_done_res    = rsp_item.done_res;
   assign rsp_last_result = rsp_item.last_result;

endmodule
